// File: rtl/pia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pia_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ACTION_W     = 3;
    localparam int POS_W        = 6;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR  = 3'd0,
        ACT_APPEND = 3'd1,
        ACT_INSERT = 3'd2,
        ACT_DELETE = 3'd3,
        ACT_READ   = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLEAR,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_GRAB,
        S_SHIFT,
        S_PLACE,
        S_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    accept;  // latch the incoming beat
        logic    rd;      // read the store at the walk pointer and step it
        logic    arm;     // data of this read is written back one slot over
        logic    grab;    // keep the last read data as the result data
        logic    place;   // write the latched value at its slot
        t_cnt_op cnt_op;
        logic    result;  // load the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_action in_act;   // action of the offered beat
        logic    in_go;    // offered beat passes its checks and changes or reads state
        t_action act;      // action of the latched item
        logic    more;     // walk pointer has entries left to move
        logic    out_free; // output register can take a result
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/pia_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pia_in_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                action;
    logic [5:0]                position;
    logic signed [31:0]        value;

    modport source (output valid, output action, output position, output value, input ready);
    modport sink   (input valid, input action, input position, input value, output ready);
endinterface

interface pia_out_if #(
    parameter int CNT_W = 7
);
    logic                      valid;
    logic                      ready;
    logic signed [31:0]        data_out;
    logic [1:0]                status;
    logic [CNT_W-1:0]          count_out;

    modport source (output valid, output data_out, output status, output count_out, input ready);
    modport sink   (input valid, input data_out, input status, input count_out, output ready);
endinterface

`default_nettype wire

// File: rtl/pia_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pia_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  pia_pkg::t_dp_stat  i_stat,
    output pia_pkg::t_dp_cmd   o_cmd
);
    import pia_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '{accept: 1'b0, rd: 1'b0, arm: 1'b0, grab: 1'b0, place: 1'b0,
                       cnt_op: CNT_HOLD, result: 1'b0};
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_RESP;
                    if (i_stat.in_go) begin
                        case (i_stat.in_act)
                            ACT_CLEAR:  o_cmd.cnt_op = CNT_CLEAR;
                            ACT_APPEND: n_state = S_PLACE;
                            ACT_INSERT: n_state = S_SHIFT;
                            ACT_DELETE: n_state = S_FETCH;
                            ACT_READ:   n_state = S_FETCH;
                            default:    n_state = S_RESP;
                        endcase
                    end
                end
            end
            S_FETCH: begin
                o_cmd.rd = 1'b1;
                n_state  = S_GRAB;
            end
            S_GRAB: begin
                o_cmd.grab = 1'b1;
                n_state    = (i_stat.act == ACT_READ) ? S_RESP : S_SHIFT;
            end
            S_SHIFT: begin
                if (i_stat.more) begin
                    o_cmd.rd  = 1'b1;
                    o_cmd.arm = 1'b1;
                end else if (i_stat.act == ACT_INSERT) begin
                    // last pending move drains this cycle
                    n_state = S_PLACE;
                end else begin
                    o_cmd.cnt_op = CNT_DEC;
                    n_state      = S_RESP;
                end
            end
            S_PLACE: begin
                o_cmd.place  = 1'b1;
                o_cmd.cnt_op = CNT_INC;
                n_state      = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.result = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/pia_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module pia_dpath #(
    parameter int CAPACITY = pia_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  pia_pkg::t_dp_cmd          i_cmd,
    output pia_pkg::t_dp_stat         o_stat,
    input  wire [2:0]                 i_action,
    input  wire [5:0]                 i_position,
    input  wire signed [31:0]         i_value,
    input  wire                       i_out_ready,
    output logic                      o_out_valid,
    output logic signed [31:0]        o_data_out,
    output logic [1:0]                o_status,
    output logic [CNT_W-1:0]          o_count_out
);
    import pia_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic signed [VALUE_W-1:0] r_mem [CAPACITY];

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_idx;
    logic [CNT_W-1:0]          r_pos;
    logic [CNT_W-1:0]          r_place;
    t_action                   r_act;
    t_status                   r_status;
    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] r_data;
    logic signed [VALUE_W-1:0] r_rd_data;
    logic                      r_wr_vld;
    logic [ADDR_W-1:0]         r_wr_addr;
    logic                      r_out_vld;
    logic signed [VALUE_W-1:0] r_out_data;
    t_status                   r_out_status;
    logic [CNT_W-1:0]          r_out_count;

    t_action                   in_act;
    t_status                   in_status;
    logic                      in_go;
    logic                      full;
    logic                      empty;
    logic                      in_range;
    logic                      ins;
    logic [CNT_W-1:0]          idx_dn;
    logic [CNT_W-1:0]          idx_up;
    logic [ADDR_W-1:0]         rd_addr;

    // checks on the offered beat
    always_comb begin
        in_act   = t_action'(i_action);
        full     = (r_count == CNT_W'(CAPACITY));
        empty    = (r_count == '0);
        in_range = (CMP_W'(i_position) < CMP_W'(r_count));
        in_status = ST_OK;
        in_go     = 1'b0;
        case (in_act)
            ACT_CLEAR: begin
                in_go = 1'b1;
            end
            ACT_APPEND: begin
                if (full) in_status = ST_FULL;
                else      in_go     = 1'b1;
            end
            ACT_INSERT: begin
                if (full)           in_status = ST_FULL;
                else if (!in_range) in_status = ST_RANGE;
                else                in_go     = 1'b1;
            end
            ACT_DELETE, ACT_READ: begin
                if (empty)          in_status = ST_EMPTY;
                else if (!in_range) in_status = ST_RANGE;
                else                in_go     = 1'b1;
            end
            default: begin
                in_go = 1'b0;
            end
        endcase
    end

    // insert walks down from the count, delete walks up from the position
    assign ins     = (r_act == ACT_INSERT);
    assign idx_dn  = r_idx - 1'b1;
    assign idx_up  = r_idx + 1'b1;
    assign rd_addr = ins ? idx_dn[ADDR_W-1:0] : r_idx[ADDR_W-1:0];

    assign o_stat = '{in_act: in_act, in_go: in_go, act: r_act,
                      more: ins ? (r_idx > r_pos) : (r_idx < r_count),
                      out_free: !r_out_vld || i_out_ready};

    // item registers and walk pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_act    <= in_act;
            r_status <= in_status;
            r_value  <= i_value;
            r_pos    <= CNT_W'(i_position);
            r_place  <= (in_act == ACT_APPEND) ? r_count : CNT_W'(i_position);
            r_idx    <= (in_act == ACT_INSERT) ? r_count : CNT_W'(i_position);
        end else if (i_cmd.rd) begin
            r_idx <= ins ? idx_dn : idx_up;
        end
        if (i_cmd.accept) begin
            r_data <= '0;
        end else if (i_cmd.grab) begin
            r_data <= r_rd_data;
        end
    end

    // store: one registered read and one write a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (r_wr_vld) begin
            r_mem[r_wr_addr] <= r_rd_data;
        end else if (i_cmd.place) begin
            r_mem[r_place[ADDR_W-1:0]] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= ins ? r_idx[ADDR_W-1:0] : idx_dn[ADDR_W-1:0];
        if (!i_rst_n) begin
            r_wr_vld <= 1'b0;
        end else begin
            r_wr_vld <= i_cmd.rd && i_cmd.arm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (i_cmd.cnt_op)
                CNT_CLEAR: r_count <= '0;
                CNT_INC:   r_count <= r_count + 1'b1;
                CNT_DEC:   r_count <= r_count - 1'b1;
                default:   r_count <= r_count;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.result) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (i_cmd.result) begin
            r_out_data   <= r_data;
            r_out_status <= r_status;
            r_out_count  <= r_count;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_data_out  = r_out_data;
    assign o_status    = r_out_status;
    assign o_count_out = r_out_count;

endmodule

`default_nettype wire

// File: rtl/positional_array_insert_delete.sv
`timescale 1ns / 1ps
`default_nettype none

// ordered array of signed 32-bit entries with clear, append, insert, delete and read
// input channel i_in: one beat holds action, position and value
// output channel o_out: one beat per input beat with data_out, status and count_out
// data_out carries the deleted or read entry and is zero otherwise
// errors (full, empty, bad position) leave the array and count untouched
// entries are moved one at a time, since the store has one read and one write port
// one item is in work at a time; a new beat is taken once the last result
//   sits in the output register, even if the receiver has not taken it yet
// when the receiver stalls the result holds in the output register and the
//   next item waits after its work is done, before loading its result
// reset empties the array (count zero) and drops any pending result;
//   store contents are not cleared and need no clearing pass
module positional_array_insert_delete #(
    parameter int CAPACITY = pia_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    pia_in_if.sink  i_in,
    pia_out_if.source o_out
);
    import pia_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer: accept, walk the store, place, respond
    pia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // store, count, item registers and output register
    pia_dpath #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_action    (i_in.action),
        .i_position  (i_in.position),
        .i_value     (i_in.value),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_data_out  (o_out.data_out),
        .o_status    (o_out.status),
        .o_count_out (o_out.count_out)
    );

endmodule

`default_nettype wire
